[design/sm3he_pkg.sv]
// SM3 hash engine package: word and digest types, port payload structs,
// initial vector, round constants and the rotate/permutation helpers.
// No dependencies.
`default_nettype none

package sm3he_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] cv_t;
	typedef logic [15:0][31:0] blk_t;

	typedef struct packed {
		logic [31:0] msg_word;
		logic [2:0]  byte_count;
		logic        end_of_message;
	} msg_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_word_t;

	localparam cv_t SM3_IV = {
		32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
		32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
	};

	localparam word_t T_LOW  = 32'h79CC4519;
	localparam word_t T_HIGH = 32'h7A879D8A;
	localparam word_t T_HIGH_ROT16 = {T_HIGH[15:0], T_HIGH[31:16]};
	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic word_t perm0(input word_t x);
		return x ^ rotl(x, 9) ^ rotl(x, 17);
	endfunction

	function automatic word_t perm1(input word_t x);
		return x ^ rotl(x, 15) ^ rotl(x, 23);
	endfunction

endpackage

`default_nettype wire

[design/sm3he_compress.sv]
// SM3 compression unit: one round per cycle, 64 rounds in all, with a
// 16-word sliding window for the message expansion.
// Depends on sm3he_pkg.
`default_nettype none

module sm3he_compress (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire sm3he_pkg::blk_t blk,
	input  wire sm3he_pkg::cv_t  cv_in,
	output logic                 done,
	output sm3he_pkg::cv_t       cv_out
);

	logic                busy_q;
	logic                done_q;
	logic [5:0]          round_q;
	sm3he_pkg::cv_t      r_q;
	sm3he_pkg::blk_t     w_q;
	sm3he_pkg::word_t    tj_q;

	sm3he_pkg::word_t    a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
	sm3he_pkg::cv_t      r_next;
	logic                low;

	always_comb begin
		low = (round_q[5:4] == 2'b00);
		a12 = sm3he_pkg::rotl(r_q[0], 12);
		ss1 = sm3he_pkg::rotl(a12 + r_q[4] + tj_q, 7);
		ss2 = ss1 ^ a12;
		if (low) begin
			ff = r_q[0] ^ r_q[1] ^ r_q[2];
			gg = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
			gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		tt1 = ff + r_q[3] + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = gg + r_q[7] + ss1 + w_q[0];
		w_new = sm3he_pkg::perm1(w_q[0] ^ w_q[7] ^ sm3he_pkg::rotl(w_q[13], 15))
			^ sm3he_pkg::rotl(w_q[3], 7) ^ w_q[10];
		r_next[0] = tt1;
		r_next[1] = r_q[0];
		r_next[2] = sm3he_pkg::rotl(r_q[1], 9);
		r_next[3] = r_q[2];
		r_next[4] = sm3he_pkg::perm0(tt2);
		r_next[5] = r_q[4];
		r_next[6] = sm3he_pkg::rotl(r_q[5], 19);
		r_next[7] = r_q[6];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			round_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w_q  <= blk;
			r_q  <= cv_in;
			tj_q <= sm3he_pkg::T_LOW;
		end else if (busy_q) begin
			w_q  <= {w_new, w_q[15:1]};
			r_q  <= r_next;
			tj_q <= (round_q == 6'd15) ? sm3he_pkg::T_HIGH_ROT16
				: sm3he_pkg::rotl(tj_q, 1);
		end
	end

	assign done   = done_q;
	assign cv_out = r_q;

endmodule

`default_nettype wire

[design/sm3_hash_engine_top.sv]
// SM3 hash engine top: input word collection, padding sequencer,
// chaining value and digest output. Depends on sm3he_pkg, sm3he_compress.
//
// Usage:
//   Message words enter on msg (valid/ready). Each word is four bytes,
//   big-endian; the word flagged end_of_message carries 0..4 valid bytes
//   (counts above 4 act as 4) in its upper positions and may be empty.
//   Every 16 words trigger one compression: a load state, then 64
//   rounds of the shared round unit and a fold into the chaining value,
//   during which msg_ready is low.
//   After the final word the sequencer appends the pad byte, zeros and
//   the 64-bit length at one word per cycle between compressions, running
//   one or two more compressions, then presents the digest on dig as eight
//   words, index 0 first, last_word set on index 7. msg_ready stays low
//   while digest words are pending; a stall on dig_ready holds the current
//   word. The engine then returns to the IV with zero length.
//   Reset (arst_n low) loads the IV, clears the length and word count and
//   leaves the engine ready for a new message.
`default_nettype none

module sm3_hash_engine_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 msg_valid,
	output logic                      msg_ready,
	input  wire sm3he_pkg::msg_word_t msg,
	output logic                      dig_valid,
	input  wire logic                 dig_ready,
	output sm3he_pkg::dig_word_t      dig
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]        state_q;
	logic [3:0]        pos_q;
	logic [63:0]       bitlen_q;
	logic              padding_q;
	logic              pad80_q;
	logic              hi_done_q;
	logic              final_q;
	logic [2:0]        idx_q;
	sm3he_pkg::cv_t    cv_q;
	sm3he_pkg::blk_t   blk_q;

	logic              msg_acc;
	logic              dig_acc;
	logic              push_en;
	sm3he_pkg::word_t  push_data;
	sm3he_pkg::word_t  last_data;
	logic [5:0]        bits_add;
	logic              cmp_done;
	sm3he_pkg::cv_t    cmp_cv;

	assign msg_ready = (state_q == ST_IDLE);
	assign dig_valid = (state_q == ST_OUT);
	assign msg_acc   = msg_valid && msg_ready;
	assign dig_acc   = dig_valid && dig_ready;

	assign dig.digest_word = cv_q[idx_q];
	assign dig.word_index  = idx_q;
	assign dig.last_word   = (idx_q == 3'd7);

	always_comb begin
		case (msg.byte_count)
			3'd0: begin
				last_data = {sm3he_pkg::PAD_BYTE, 24'h000000};
				bits_add  = 6'd0;
			end
			3'd1: begin
				last_data = {msg.msg_word[31:24], sm3he_pkg::PAD_BYTE, 16'h0000};
				bits_add  = 6'd8;
			end
			3'd2: begin
				last_data = {msg.msg_word[31:16], sm3he_pkg::PAD_BYTE, 8'h00};
				bits_add  = 6'd16;
			end
			3'd3: begin
				last_data = {msg.msg_word[31:8], sm3he_pkg::PAD_BYTE};
				bits_add  = 6'd24;
			end
			default: begin
				last_data = msg.msg_word;
				bits_add  = 6'd32;
			end
		endcase
		if (!msg.end_of_message)
			bits_add = 6'd32;
	end

	always_comb begin
		push_en   = 1'b0;
		push_data = '0;
		if (state_q == ST_IDLE) begin
			push_en   = msg_acc;
			push_data = msg.end_of_message ? last_data : msg.msg_word;
		end else if (state_q == ST_PAD) begin
			push_en = 1'b1;
			if (pad80_q)
				push_data = {sm3he_pkg::PAD_BYTE, 24'h000000};
			else if (pos_q == 4'd14)
				push_data = bitlen_q[63:32];
			else if (pos_q == 4'd15 && hi_done_q)
				push_data = bitlen_q[31:0];
			else
				push_data = '0;
		end
	end

	sm3he_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_LOAD),
		.blk    (blk_q),
		.cv_in  (cv_q),
		.done   (cmp_done),
		.cv_out (cmp_cv)
	);

	always_ff @(posedge clk) begin
		if (push_en)
			blk_q <= {push_data, blk_q[15:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			bitlen_q  <= '0;
			padding_q <= 1'b0;
			pad80_q   <= 1'b0;
			hi_done_q <= 1'b0;
			final_q   <= 1'b0;
			idx_q     <= '0;
			cv_q      <= sm3he_pkg::SM3_IV;
		end else begin
			if (push_en)
				pos_q <= pos_q + 4'd1;
			unique case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						bitlen_q <= bitlen_q + {58'd0, bits_add};
						if (msg.end_of_message) begin
							padding_q <= 1'b1;
							pad80_q   <= (msg.byte_count[2] == 1'b1);
							hi_done_q <= 1'b0;
						end
						if (pos_q == 4'd15)
							state_q <= ST_LOAD;
						else if (msg.end_of_message)
							state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					if (pad80_q)
						pad80_q <= 1'b0;
					else if (pos_q == 4'd14)
						hi_done_q <= 1'b1;
					else if (pos_q == 4'd15 && hi_done_q) begin
						final_q   <= 1'b1;
						padding_q <= 1'b0;
					end
					if (pos_q == 4'd15)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (cmp_done) begin
						cv_q <= cv_q ^ cmp_cv;
						if (final_q)
							state_q <= ST_OUT;
						else if (padding_q)
							state_q <= ST_PAD;
						else
							state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (dig_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							cv_q     <= sm3he_pkg::SM3_IV;
							bitlen_q <= '0;
							final_q  <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		msg_ready |-> !dig_valid)
		else $error("input open while digest pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmp_done |-> (state_q == ST_WAIT))
		else $error("compression finished outside wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(dig_acc && dig.last_word) |=> (cv_q == sm3he_pkg::SM3_IV && bitlen_q == 64'd0
			&& pos_q == 4'd0))
		else $error("engine not returned to IV after digest");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (pos_q == 4'd0))
		else $error("block loaded with partial word count");

endmodule

`default_nettype wire

[tb/sm3_hash_engine_checker.sv]
// Checker for sm3_hash_engine_top: watches the message and digest channels,
// predicts the SM3 digest of each message and compares every digest word.
// Depends on sm3he_pkg for the payload types.
module sm3_hash_engine_checker
	import sm3he_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      msg_valid,
	input  wire logic      msg_ready,
	input  wire msg_word_t msg,
	input  wire logic      dig_valid,
	input  wire logic      dig_ready,
	input  wire dig_word_t dig,
	output int unsigned    fail_count,
	output int unsigned    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam cv_t START_VALUE = {
		32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
		32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
	};
	localparam word_t ROUND_K_EARLY = 32'h79CC4519;
	localparam word_t ROUND_K_LATE  = 32'h7A879D8A;
	localparam word_t PAD_WORD      = 32'h80;

	cv_t         chain;
	blk_t        blk_words;
	int unsigned fill;
	logic [63:0] nbits;
	dig_word_t   digest_due[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic word_t rot_left(input word_t x, input int unsigned n);
		logic [63:0] d;
		d = {x, x} << (n % 32);
		return d[63:32];
	endfunction

	function automatic word_t mix_p0(input word_t x);
		return x ^ rot_left(x, 9) ^ rot_left(x, 17);
	endfunction

	function automatic word_t mix_p1(input word_t x);
		return x ^ rot_left(x, 15) ^ rot_left(x, 23);
	endfunction

	function automatic cv_t compress(input cv_t cv, input blk_t blk);
		word_t w [0:67];
		word_t r [0:7];
		word_t a12, tj, ss1, ss2, ff, gg, tt1, tt2;
		cv_t   next_cv;
		for (int i = 0; i < 16; i++)
			w[i] = blk[i];
		for (int i = 16; i < 68; i++)
			w[i] = mix_p1(w[i-16] ^ w[i-9] ^ rot_left(w[i-3], 15))
				^ rot_left(w[i-13], 7) ^ w[i-6];
		for (int i = 0; i < 8; i++)
			r[i] = cv[i];
		for (int i = 0; i < 64; i++) begin
			a12 = rot_left(r[0], 12);
			tj = (i < 16) ? ROUND_K_EARLY : ROUND_K_LATE;
			ss1 = rot_left(a12 + r[4] + rot_left(tj, i), 7);
			ss2 = ss1 ^ a12;
			if (i < 16) begin
				ff = r[0] ^ r[1] ^ r[2];
				gg = r[4] ^ r[5] ^ r[6];
			end else begin
				ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
				gg = (r[4] & r[5]) | (~r[4] & r[6]);
			end
			tt1 = ff + r[3] + ss2 + (w[i] ^ w[i+4]);
			tt2 = gg + r[7] + ss1 + w[i];
			r[3] = r[2];
			r[2] = rot_left(r[1], 9);
			r[1] = r[0];
			r[0] = tt1;
			r[7] = r[6];
			r[6] = rot_left(r[5], 19);
			r[5] = r[4];
			r[4] = mix_p0(tt2);
		end
		for (int i = 0; i < 8; i++)
			next_cv[i] = cv[i] ^ r[i];
		return next_cv;
	endfunction

	task automatic load_word(input word_t w);
		blk_words[fill] = w;
		fill++;
		if (fill == 16) begin
			chain = compress(chain, blk_words);
			fill = 0;
		end
	endtask

	task automatic absorb(input msg_word_t m);
		int unsigned nb;
		word_t       keep;
		word_t       w;
		dig_word_t   d;
		if (!m.end_of_message) begin
			nbits += 64'd32;
			load_word(m.msg_word);
		end else begin
			nb = (m.byte_count > 3'd4) ? 4 : m.byte_count;
			nbits += nb * 8;
			keep = (nb == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * nb));
			w = m.msg_word & keep;
			if (nb < 4) begin
				w |= PAD_WORD << (24 - 8 * nb);
				load_word(w);
			end else begin
				load_word(w);
				load_word(PAD_WORD << 24);
			end
			if (fill > 14)
				while (fill != 0)
					load_word('0);
			while (fill < 14)
				load_word('0);
			load_word(nbits[63:32]);
			load_word(nbits[31:0]);
			for (int i = 0; i < 8; i++) begin
				d.digest_word = chain[i];
				d.word_index = i[2:0];
				d.last_word = (i == 7);
				digest_due.insert(digest_due.size(), d);
			end
			chain = START_VALUE;
			fill = 0;
			nbits = '0;
		end
	endtask

	task automatic report(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	task automatic check_word(input dig_word_t got);
		dig_word_t want;
		if (digest_due.size() == 0) begin
			report($sformatf("digest word %h index %0d with nothing expected",
				got.digest_word, got.word_index));
		end else begin
			want = digest_due.pop_front();
			if (got.digest_word !== want.digest_word)
				report($sformatf("digest_word got %h want %h",
					got.digest_word, want.digest_word));
			if (got.word_index !== want.word_index)
				report($sformatf("word_index got %0d want %0d",
					got.word_index, want.word_index));
			if (got.last_word !== want.last_word)
				report($sformatf("last_word got %b want %b",
					got.last_word, want.last_word));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain = START_VALUE;
			blk_words = '0;
			fill = 0;
			nbits = '0;
			digest_due.delete();
		end else begin
			if (msg_valid && msg_ready)
				absorb(msg);
			if (dig_valid && dig_ready)
				check_word(dig);
		end
		pending = digest_due.size();
	end

endmodule

[tb/sm3_hash_engine_top_test.sv]
// Testbench top for sm3_hash_engine_top: sends messages in bursts, stalls the
// digest side and prints the verdict. Depends on sm3he_pkg, the engine RTL
// and sm3_hash_engine_checker.
module sm3_hash_engine_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sm3he_pkg::*;

	localparam int unsigned DIRECTED_WORDS = 23;
	localparam int unsigned RANDOM_WORDS   = 450;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        msg_valid = 1'b0;
	logic        msg_ready;
	msg_word_t   msg = '0;
	logic        dig_valid;
	logic        dig_ready = 1'b0;
	dig_word_t   dig;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned burst_left = 0;
	int unsigned words_sent = 0;
	int unsigned ready_run = 0;

	sm3_hash_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig       (dig)
	);

	sm3_hash_engine_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_valid  (msg_valid),
		.msg_ready  (msg_ready),
		.msg        (msg),
		.dig_valid  (dig_valid),
		.dig_ready  (dig_ready),
		.dig        (dig),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (ready_run == 0) begin
			if ($urandom_range(0, 2) == 0) begin
				dig_ready <= 1'b0;
				ready_run <= $urandom_range(1, 10);
			end else begin
				dig_ready <= 1'b1;
				ready_run <= $urandom_range(1, 24);
			end
		end else begin
			ready_run <= ready_run - 1;
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL sm3_hash_engine_top");
		$finish;
	end

	task automatic send_word(input word_t data, input logic [2:0] count, input logic eom);
		int unsigned gap;
		msg_word_t   item;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 7);
			if (gap != 0) begin
				msg_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		item.msg_word = data;
		item.byte_count = count;
		item.end_of_message = eom;
		msg_valid <= 1'b1;
		msg <= item;
		@(posedge clk);
		while (!msg_ready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		words_sent++;
	endtask

	task automatic send_message(input int unsigned len, input logic [2:0] tail_count);
		for (int unsigned k = 1; k < len; k++)
			send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
		send_word($urandom, tail_count, 1'b1);
	endtask

	// hold the sender until every digest word has come back
	task automatic drain();
		msg_valid <= 1'b0;
		burst_left = 0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	initial begin
		int unsigned len;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(32'h0000_0000, 3'd0, 1'b1);
		send_word(32'h6162_6300, 3'd3, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd2, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd5, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd6, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
		for (int k = 0; k < 14; k++)
			send_word((k % 2) ? 32'h0000_0000 : 32'hFFFF_FFFF,
				(k % 2) ? 3'd0 : 3'd7, 1'b0);
		send_word(32'hA5C3_5A3C, 3'd4, 1'b1);
		drain();

		while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
			if ($urandom_range(0, 7) == 0)
				len = $urandom_range(17, 48);
			else
				len = $urandom_range(1, 16);
			send_message(len, 3'($urandom_range(0, 7)));
			if ($urandom_range(0, 9) == 0)
				drain();
		end

		msg_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("PASS sm3_hash_engine_top");
		else
			$display("FAIL sm3_hash_engine_top");
		$finish;
	end

endmodule

[filelist.f]
design/sm3he_pkg.sv
design/sm3he_compress.sv
design/sm3_hash_engine_top.sv
tb/sm3_hash_engine_checker.sv
tb/sm3_hash_engine_top_test.sv
